// ----- hw/rtl/symmetric_nearest_neighbour_filter_defines.svh -----
// Assertion macros for the symmetric nearest neighbour filter.
// Included by snnf_queue, the module that carries concurrent checks.
`ifndef SYMMETRIC_NEAREST_NEIGHBOUR_FILTER_DEFINES_SVH
`define SYMMETRIC_NEAREST_NEIGHBOUR_FILTER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SNNF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("snnf assertion failed");

// next-cycle implication, disabled in reset
`define SNNF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("snnf assertion failed");

`endif

// ----- hw/rtl/snnf_pkg.sv -----
// Shared types and constants of the symmetric nearest neighbour filter.
// No dependencies.
package snnf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HALF   = 3;
    localparam int PIX_W      = 16;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 16;
    localparam int WID_W      = 11;
    localparam int RING_W     = 3;
    localparam int ADDR_W     = RING_W + COL_W;
    localparam int QDEPTH     = 2;

    localparam logic [1:0] REG_HALF_X = 2'd0;
    localparam logic [1:0] REG_HALF_Y = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    typedef struct packed {
        logic              wr;
        logic [ADDR_W-1:0] waddr;
        logic [PIX_W-1:0]  wdata;
        logic              emit;
        logic              last;
        logic [COL_W-1:0]  x;
        logic [ROW_W-1:0]  y;
        logic [WID_W-1:0]  w;
        logic [ROW_W-1:0]  h;
        logic [1:0]        hx;
        logic [1:0]        hy;
    } t_job;

endpackage

// ----- hw/rtl/snnf_front.sv -----
// Front end: configuration registers, raster counters and output scheduling.
// Depends on snnf_pkg; feeds jobs into snnf_queue.
module snnf_front import snnf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_opcode,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic             i_q_full,
    output logic             o_push,
    output t_job             o_job
);

    localparam logic [2:0] F_IDLE    = 3'd0;
    localparam logic [2:0] F_MUL_IN  = 3'd1;
    localparam logic [2:0] F_MUL_OUT = 3'd2;
    localparam logic [2:0] F_CMP     = 3'd3;
    localparam logic [2:0] F_PUSH    = 3'd4;

    logic [2:0]        r_state;
    logic [1:0]        r_hx, r_hy;
    logic [WID_W-1:0]  r_wcfg;
    logic [ROW_W-1:0]  r_hcfg;
    logic [COL_W-1:0]  r_in_col, r_out_col;
    logic [ROW_W-1:0]  r_in_row, r_out_row;
    logic              r_wr, r_emit;
    logic [ADDR_W-1:0] r_waddr;
    logic [PIX_W-1:0]  r_wdata;
    logic [27:0]       r_il, r_ol;

    logic [WID_W-1:0]  w_w;
    logic [ROW_W-1:0]  w_h;
    logic [ROW_W-1:0]  w_hh;
    logic [WID_W-1:0]  w_wh;
    logic [1:0]        w_hye, w_hxe;
    logic [12:0]       w_lag;
    logic [26:0]       w_prod_in, w_prod_out;
    logic              w_acc;
    logic [WID_W:0]    w_in_ncol, w_out_ncol;
    logic [ROW_W:0]    w_out_nrow;
    logic              w_last;

    assign w_w  = (r_wcfg == '0) ? WID_W'(1) :
                  (r_wcfg > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : r_wcfg;
    assign w_h  = (r_hcfg == '0) ? ROW_W'(1) : r_hcfg;
    assign w_hh = (w_h - ROW_W'(1)) >> 1;
    assign w_wh = (w_w - WID_W'(1)) >> 1;
    assign w_hye = (w_hh < ROW_W'(r_hy)) ? w_hh[1:0] : r_hy;
    assign w_hxe = (w_wh < WID_W'(r_hx)) ? w_wh[1:0] : r_hx;
    assign w_lag = 13'(w_hye) * 13'(w_w) + 13'(w_hxe);
    assign w_prod_in  = 27'(r_in_row) * 27'(w_w);
    assign w_prod_out = 27'(r_out_row) * 27'(w_w);

    assign o_ready = (r_state == F_IDLE);
    assign w_acc   = i_valid && o_ready;
    assign o_push  = (r_state == F_PUSH) && !i_q_full;

    assign w_in_ncol  = {1'b0, r_in_col} + (WID_W+1)'(1);
    assign w_out_ncol = {1'b0, r_out_col} + (WID_W+1)'(1);
    assign w_out_nrow = (w_out_ncol >= {1'b0, w_w}) ? ({1'b0, r_out_row} + (ROW_W+1)'(1))
                                                    : {1'b0, r_out_row};
    assign w_last = r_emit && (w_out_nrow >= {1'b0, w_h});

    always_comb begin
        o_job       = '0;
        o_job.wr    = r_wr;
        o_job.waddr = r_waddr;
        o_job.wdata = r_wdata;
        o_job.emit  = r_emit;
        o_job.last  = w_last;
        o_job.x     = r_out_col;
        o_job.y     = r_out_row;
        o_job.w     = w_w;
        o_job.h     = w_h;
        o_job.hx    = r_hx;
        o_job.hy    = r_hy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hx   <= 2'd1;
            r_hy   <= 2'd1;
            r_wcfg <= WID_W'(1024);
            r_hcfg <= ROW_W'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_HALF_X: r_hx   <= i_cfg_data[1:0];
                REG_HALF_Y: r_hy   <= i_cfg_data[1:0];
                REG_WIDTH:  r_wcfg <= i_cfg_data[WID_W-1:0];
                REG_HEIGHT: r_hcfg <= i_cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_wr      <= 1'b0;
            r_emit    <= 1'b0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (w_acc) begin
                        if (!i_opcode && (r_in_row < w_h)) begin
                            r_wr    <= 1'b1;
                            r_emit  <= 1'b0;
                            r_waddr <= {r_in_row[RING_W-1:0], r_in_col};
                            r_wdata <= i_pixel;
                            if (w_in_ncol >= {1'b0, w_w}) begin
                                r_in_col <= '0;
                                r_in_row <= r_in_row + ROW_W'(1);
                            end else begin
                                r_in_col <= w_in_ncol[COL_W-1:0];
                            end
                            r_state <= F_MUL_IN;
                        end else if ((r_in_row >= w_h) && (r_out_row < w_h)) begin
                            r_wr    <= 1'b0;
                            r_emit  <= 1'b1;
                            r_state <= F_PUSH;
                        end
                    end
                end
                F_MUL_IN: begin
                    r_il    <= 28'(w_prod_in) + 28'(r_in_col);
                    r_state <= F_MUL_OUT;
                end
                F_MUL_OUT: begin
                    r_ol    <= 28'(w_prod_out) + 28'(r_out_col) + 28'(w_lag);
                    r_state <= F_CMP;
                end
                F_CMP: begin
                    r_emit  <= (r_out_row < w_h) && (r_il > r_ol);
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        if (r_emit) begin
                            if (w_last) begin
                                r_in_col  <= '0;
                                r_in_row  <= '0;
                                r_out_col <= '0;
                                r_out_row <= '0;
                            end else begin
                                r_out_row <= w_out_nrow[ROW_W-1:0];
                                r_out_col <= (w_out_ncol >= {1'b0, w_w}) ? '0
                                                                       : w_out_ncol[COL_W-1:0];
                            end
                        end
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/snnf_queue.sv -----
// Two-entry job queue between front and back end.
// Depends on snnf_pkg and the assertion macro header.
`include "symmetric_nearest_neighbour_filter_defines.svh"
module snnf_queue import snnf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job       r_buf [QDEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'(QDEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_buf[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    `SNNF_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= 2'(QDEPTH))
    `SNNF_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `SNNF_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid)
    `SNNF_ASSERT_NXT(a_push_grows, i_clk, i_rst_n, i_push && !i_pop, r_cnt == $past(r_cnt) + 2'd1)

endmodule

// ----- hw/rtl/snnf_back.sv -----
// Back end: row store, window pair walk, rounding divider and result register.
// Depends on snnf_pkg; takes jobs from snnf_queue.
module snnf_back import snnf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_job             i_job,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [PIX_W-1:0] o_data,
    output logic             o_last
);

    localparam int SUM_W = 21;
    localparam int NUM_W = 22;
    localparam int N_W   = 5;
    localparam int DEN_W = N_W + 1;
    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_SETUP = 3'd1;
    localparam logic [2:0] B_CTR   = 3'd2;
    localparam logic [2:0] B_CWAIT = 3'd3;
    localparam logic [2:0] B_PAIR  = 3'd4;
    localparam logic [2:0] B_FLUSH = 3'd5;
    localparam logic [2:0] B_DIV   = 3'd6;
    localparam logic [2:0] B_OUT   = 3'd7;

    function automatic logic [PIX_W-1:0] closer(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b,
                                                input logic [PIX_W-1:0] c);
        logic [PIX_W:0] s;
        logic [PIX_W:0] c2;
        logic [PIX_W-1:0] r;
        s  = {1'b0, a} + {1'b0, b};
        c2 = {c, 1'b0};
        if (s > c2)      r = (a < b) ? a : b;
        else if (s < c2) r = (a > b) ? a : b;
        else             r = c;
        return r;
    endfunction

    logic [PIX_W-1:0]  r_mem [(1 << ADDR_W)];
    logic [PIX_W-1:0]  r_rda, r_rdb;
    logic [2:0]        r_state;
    t_job              r_job;
    logic [1:0]        r_hxw, r_hyw;
    logic [N_W-1:0]    r_n;
    logic [PIX_W-1:0]  r_c;
    logic [1:0]        r_i;
    logic [2:0]        r_j;
    logic              r_pv;
    logic [SUM_W-1:0]  r_sum;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_rem;
    logic [4:0]        r_dcnt;
    logic [PIX_W-1:0]  r_res;

    logic [ADDR_W-1:0] w_addr_a, w_addr_b;
    logic [RING_W-1:0] w_ra, w_rb;
    logic [COL_W-1:0]  w_ca, w_cb;
    logic [SUM_W-1:0]  w_sum_nx;
    logic              w_pair_end;
    logic [1:0]        w_hxw, w_hyw;
    logic [WID_W-1:0]  w_xr;
    logic [ROW_W-1:0]  w_yr;
    logic [DEN_W:0]    w_rem_sh;
    logic              w_qbit;
    logic [NUM_W-1:0]  w_num_nx;
    logic [DEN_W-1:0]  w_den;

    assign o_pop   = (r_state == B_IDLE) && i_valid;
    assign o_valid = (r_state == B_OUT);
    assign o_data  = r_res;
    assign o_last  = r_job.last;

    // window half sizes clipped at the borders
    always_comb begin
        w_xr  = r_job.w - WID_W'(1) - WID_W'(r_job.x);
        w_yr  = r_job.h - ROW_W'(1) - r_job.y;
        w_hxw = r_job.hx;
        if (r_job.x < COL_W'(w_hxw)) w_hxw = r_job.x[1:0];
        if (w_xr < WID_W'(w_hxw))    w_hxw = w_xr[1:0];
        if (WID_W'(r_job.x) >= r_job.w) w_hxw = 2'd0;
        w_hyw = r_job.hy;
        if (r_job.y < ROW_W'(w_hyw)) w_hyw = r_job.y[1:0];
        if (w_yr < ROW_W'(w_hyw))    w_hyw = w_yr[1:0];
    end

    assign w_ra = r_job.y[RING_W-1:0] - RING_W'(r_i);
    assign w_rb = r_job.y[RING_W-1:0] + RING_W'(r_i);
    assign w_ca = r_job.x - COL_W'(r_hxw) + COL_W'(r_j);
    assign w_cb = r_job.x + COL_W'(r_hxw) - COL_W'(r_j);
    assign w_addr_a = (r_state == B_PAIR) ? {w_ra, w_ca}
                                          : {r_job.y[RING_W-1:0], r_job.x};
    assign w_addr_b = {w_rb, w_cb};

    assign w_sum_nx   = r_sum + SUM_W'(closer(r_rda, r_rdb, r_c));
    assign w_pair_end = (r_i == r_hyw) && (r_j == {r_hxw, 1'b0});

    assign w_den    = {r_n, 1'b0};
    assign w_rem_sh = {r_rem, r_num[NUM_W-1]};
    assign w_qbit   = (w_rem_sh >= {1'b0, w_den});
    assign w_num_nx = {r_num[NUM_W-2:0], w_qbit};

    always_ff @(posedge i_clk) begin
        if ((r_state == B_IDLE) && i_valid && i_job.wr) r_mem[i_job.waddr] <= i_job.wdata;
        r_rda <= r_mem[w_addr_a];
        r_rdb <= r_mem[w_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_pv    <= 1'b0;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (i_valid) begin
                        r_job <= i_job;
                        if (i_job.emit) r_state <= B_SETUP;
                    end
                end
                B_SETUP: begin
                    r_hxw   <= w_hxw;
                    r_hyw   <= w_hyw;
                    r_n     <= N_W'((6'({1'b0, w_hyw, 1'b1}) * 6'({1'b0, w_hxw, 1'b1})) >> 1);
                    r_state <= B_CTR;
                end
                B_CTR: r_state <= B_CWAIT;
                B_CWAIT: begin
                    r_c   <= r_rda;
                    r_sum <= '0;
                    r_pv  <= 1'b0;
                    if (r_hxw != 2'd0) begin
                        r_i <= 2'd0;
                        r_j <= 3'(r_hxw) + 3'd1;
                    end else begin
                        r_i <= 2'd1;
                        r_j <= 3'd0;
                    end
                    if (r_n == '0) begin
                        r_res   <= r_rda;
                        r_state <= B_OUT;
                    end else begin
                        r_state <= B_PAIR;
                    end
                end
                B_PAIR: begin
                    r_pv <= 1'b1;
                    if (r_pv) r_sum <= w_sum_nx;
                    if (w_pair_end) begin
                        r_state <= B_FLUSH;
                    end else if (r_j == {r_hxw, 1'b0}) begin
                        r_i <= r_i + 2'd1;
                        r_j <= 3'd0;
                    end else begin
                        r_j <= r_j + 3'd1;
                    end
                end
                B_FLUSH: begin
                    r_pv    <= 1'b0;
                    r_num   <= {w_sum_nx, 1'b0} + NUM_W'(r_n);
                    r_rem   <= '0;
                    r_dcnt  <= 5'(NUM_W);
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    r_rem  <= w_qbit ? DEN_W'(w_rem_sh - {1'b0, w_den}) : w_rem_sh[DEN_W-1:0];
                    r_num  <= w_num_nx;
                    r_dcnt <= r_dcnt - 5'd1;
                    if (r_dcnt == 5'd1) begin
                        r_res   <= w_num_nx[PIX_W-1:0];
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (i_ready) r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/symmetric_nearest_neighbour_filter.sv -----
// Symmetric nearest neighbour filter, top level.
// Depends on snnf_pkg, snnf_front, snnf_queue and snnf_back.
//
//  channel   dir  handshake          payload
//  s_axis    in   tvalid / tready    tdata: pixel_in; tuser: opcode
//  m_axis    out  tvalid / tready    tdata: pixel_out; tlast: frame_last
//  cfg       in   i_cfg_we           i_cfg_idx, i_cfg_data
//
// Front end takes one word at a time: two counter multiplies and one compare per stored word.
// Back end writes a store-only word into the row store; for a result it does
// one row-store read per window pair (up to 24) and a 22-step rounding divider.
// A two-word queue lets the front accept while a result waits on m_axis.
// Reset is synchronous, active low; the row store is not cleared.
module symmetric_nearest_neighbour_filter import snnf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [15:0]      i_cfg_data,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [PIX_W-1:0] s_axis_tdata,   // [15:0] pixel_in
    input  logic             s_axis_tuser,   // [0] opcode
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [PIX_W-1:0] m_axis_tdata,   // [15:0] pixel_out
    output logic             m_axis_tlast
);

    logic w_push, w_full, w_pop, w_qvalid;
    t_job w_job_in, w_job_out;

    snnf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_opcode   (s_axis_tuser),
        .i_pixel    (s_axis_tdata),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_job      (w_job_in)
    );

    snnf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_job   (w_job_out)
    );

    snnf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qvalid),
        .i_job   (w_job_out),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

// ----- sim/snnf_checker.sv -----
// Scoreboard for the symmetric nearest neighbour filter: watches the input,
// config and output channels, predicts each filtered pixel and compares.
// Depends on snnf_pkg.
module snnf_checker import snnf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [15:0]      i_cfg_data,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [PIX_W-1:0] s_axis_tdata,
    input  logic             s_axis_tuser,
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic [PIX_W-1:0] m_axis_tdata,
    input  logic             m_axis_tlast,
    output int               o_errors,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING = 2 * MAX_HALF + 2;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             last;
    } t_filtered;

    logic [PIX_W-1:0] rows [RING*MAX_WIDTH];
    t_filtered        filtered_q[$];
    int unsigned      half_x, half_y, img_w, img_h;
    int unsigned      in_col, in_row, out_col, out_row;
    int               errors;

    assign o_errors  = errors;
    assign o_pending = filtered_q.size();

    function automatic int unsigned min2(int unsigned a, int unsigned b);
        return a < b ? a : b;
    endfunction

    function automatic int unsigned pix_at(int unsigned r, int unsigned c);
        return rows[(r % RING) * MAX_WIDTH + (c % MAX_WIDTH)];
    endfunction

    function automatic int unsigned nearer(int unsigned a, int unsigned b, int unsigned c);
        if (a + b > 2 * c) return min2(a, b);
        if (a + b < 2 * c) return a > b ? a : b;
        return c;
    endfunction

    task automatic predict_pixel(int unsigned w, int unsigned h);
        int unsigned x, y, hxw, hyw, c, sum, n, res;
        t_filtered   f;
        x = out_col;
        y = out_row;
        hxw = (x < w) ? min2(half_x, min2(x, w - 1 - x)) : 0;
        hyw = min2(half_y, min2(y, h - 1 - y));
        c = pix_at(y, x);
        sum = 0;
        for (int i = 1; i <= hyw; i++)
            for (int j = 0; j <= 2 * hxw; j++)
                sum += nearer(pix_at(y - i, x - hxw + j), pix_at(y + i, x + hxw - j), c);
        for (int j = 1; j <= hxw; j++)
            sum += nearer(pix_at(y, x - j), pix_at(y, x + j), c);
        n = ((2 * hyw + 1) * (2 * hxw + 1)) >> 1;
        res = n != 0 ? (2 * sum + n) / (2 * n) : c;
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
        f.pix = res[PIX_W-1:0];
        f.last = 1'b0;
        if (out_row >= h) begin
            f.last = 1'b1;
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end
        filtered_q.push_back(f);
    endtask

    task automatic take_word(logic drain, logic [PIX_W-1:0] value);
        int unsigned w, h;
        longint unsigned lag, il, ol;
        w = img_w == 0 ? 1 : min2(img_w, MAX_WIDTH);
        h = img_h == 0 ? 1 : img_h;
        lag = longint'(min2(half_y, (h - 1) / 2)) * w + min2(half_x, (w - 1) / 2);
        if (!drain && in_row < h) begin
            rows[(in_row % RING) * MAX_WIDTH + (in_col % MAX_WIDTH)] = value;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            il = longint'(in_row) * w + in_col;
            ol = longint'(out_row) * w + out_col;
            if (out_row < h && il > ol + lag) predict_pixel(w, h);
        end else if (in_row >= h && out_row < h) begin
            predict_pixel(w, h);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            half_x <= 1; half_y <= 1; img_w <= 1024; img_h <= 1024;
            in_col <= 0; in_row <= 0; out_col <= 0; out_row <= 0;
            errors <= 0;
            filtered_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_HALF_X: half_x = i_cfg_data[1:0];
                    REG_HALF_Y: half_y = i_cfg_data[1:0];
                    REG_WIDTH:  img_w  = i_cfg_data[10:0];
                    REG_HEIGHT: img_h  = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) take_word(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (filtered_q.size() == 0) begin
                    $display("%0t: unexpected word: actual pix %h last %b", $time,
                             m_axis_tdata, m_axis_tlast);
                    errors = errors + 1;
                end else begin
                    t_filtered f;
                    f = filtered_q.pop_front();
                    if (f.pix !== m_axis_tdata || f.last !== m_axis_tlast) begin
                        $display("%0t: mismatch: expected pix %h last %b, actual pix %h last %b",
                                 $time, f.pix, f.last, m_axis_tdata, m_axis_tlast);
                        errors = errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- sim/tb_symmetric_nearest_neighbour_filter.sv -----
// Testbench top for the symmetric nearest neighbour filter: drives frames of
// random pixels over several window and image settings and gives the verdict.
// Depends on snnf_pkg, snnf_checker and the filter RTL.
module tb_symmetric_nearest_neighbour_filter import snnf_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [1:0]       i_cfg_idx = REG_HALF_X;
    logic [15:0]      i_cfg_data = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [PIX_W-1:0] s_axis_tdata = '0;
    logic             s_axis_tuser = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [PIX_W-1:0] m_axis_tdata;
    logic             m_axis_tlast;
    int               errors, pending;
    int               words_sent = 0;
    bit               hold_off = 1'b0;
    bit               calm = 1'b0;

    always #5 i_clk = ~i_clk;

    symmetric_nearest_neighbour_filter DUT (.*);
    snnf_checker u_checker (.*, .o_errors(errors), .o_pending(pending));

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_word(logic drain, logic [PIX_W-1:0] value);
        while (!calm && $urandom_range(99) < 24) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= drain;
        s_axis_tdata <= value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // one frame; extremes mode uses full-scale and zero pixels
    // a stray pixel after the frame only while results are still owed
    task automatic run_frame(int hx, int hy, int w, int h, bit extremes);
        int lag;
        settle();
        lag = ((hy < (h - 1) / 2) ? hy : (h - 1) / 2) * w
            + ((hx < (w - 1) / 2) ? hx : (w - 1) / 2);
        write_reg(REG_HALF_X, 16'(hx));
        write_reg(REG_HALF_Y, 16'(hy));
        write_reg(REG_WIDTH, 16'(w));
        write_reg(REG_HEIGHT, 16'(h));
        send_word(1'b1, 16'($urandom));
        for (int i = 0; i < w * h; i++)
            send_word(1'b0, extremes ? ($urandom_range(1) ? 16'hFFFF : 16'h0000)
                                     : 16'($urandom));
        if (lag > 0 && $urandom_range(3) == 0) send_word(1'b0, 16'($urandom));
        for (int i = 0; i < lag + 4; i++) send_word(1'b1, 16'($urandom));
    endtask

    always @(posedge i_clk) begin
        if (hold_off) m_axis_tready <= 1'b0;
        else m_axis_tready <= calm || $urandom_range(99) >= 24;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_frame(0, 0, 3, 2, 1'b1);
        run_frame(3, 3, 7, 7, 1'b1);
        run_frame(1, 2, 1, 5, 1'b0);
        run_frame(2, 0, 6, 1, 1'b0);
        hold_off = 1'b1;
        fork
            run_frame(1, 1, 8, 6, 1'b0);
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join
        while (words_sent < 800) begin
            calm = (words_sent > 350 && words_sent < 550);
            run_frame($urandom_range(3), $urandom_range(3), $urandom_range(1, 12),
                      $urandom_range(1, 10), 1'b0);
        end
        calm = 1'b0;
        run_frame(3, 3, 1024, 1, 1'b0);
        run_frame(1, 0, 1, 8, 1'b0);
        settle();
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
